// ===== sv/jsu_pkg.sv =====
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helper functions of the JSON string
// unescaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package jsu_pkg;

	// held bytes of a \u escape or of a surrogate pair tail
	localparam int HoldDepth = 6;
	// the byte that completes a pair is never stored, it decides the pair
	localparam int HbDepth   = HoldDepth - 1;
	// bytes still to decode: the new byte plus any replayed ones
	localparam int RbDepth   = HoldDepth;
	// most result bytes kept for one input byte
	localparam logic [3:0] MaxRes = 4'd12;

	// characters
	localparam logic [7:0] ChBslash = 8'h5C;
	localparam logic [7:0] ChLowB   = 8'h62;
	localparam logic [7:0] ChLowF   = 8'h66;
	localparam logic [7:0] ChLowN   = 8'h6E;
	localparam logic [7:0] ChLowR   = 8'h72;
	localparam logic [7:0] ChLowT   = 8'h74;
	localparam logic [7:0] ChLowU   = 8'h75;

	// control characters of the simple escapes
	localparam logic [7:0] CtlBs = 8'h08;
	localparam logic [7:0] CtlFf = 8'h0C;
	localparam logic [7:0] CtlLf = 8'h0A;
	localparam logic [7:0] CtlCr = 8'h0D;
	localparam logic [7:0] CtlHt = 8'h09;

	// code points
	localparam logic [20:0] CpRepl   = 21'h00FFFD;
	localparam logic [20:0] SuppBase = 21'h010000;
	localparam logic [5:0]  SurHiTag = 6'b110110;
	localparam logic [5:0]  SurLoTag = 6'b110111;

	typedef enum logic [1:0] {
		MD_PLAIN,
		MD_ESC,
		MD_HEX,
		MD_PAIR
	} mode_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_RUN,
		BK_EMIT
	} bk_state_t;

	// one raw byte with its hex digit classification
	typedef struct packed {
		logic [7:0] b;
		logic       hok;
		logic [3:0] hv;
	} ent_t;

	// entry of the queue between front and back end
	typedef struct packed {
		ent_t ent;
		logic last;
	} lnk_t;

	// one result request
	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		logic       eos;
	} res_t;

	typedef struct packed {
		logic [2:0]      n;
		logic [3:0][7:0] b;
	} utf8_t;

	function automatic ent_t classify(input logic [7:0] b);
		ent_t r;
		r.b   = b;
		r.hok = 1'b0;
		r.hv  = 4'h0;
		if (b inside {[8'h30:8'h39]}) begin
			r.hok = 1'b1;
			r.hv  = b[3:0];
		end else if (b inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
			r.hok = 1'b1;
			r.hv  = b[3:0] + 4'd9;
		end
		return r;
	endfunction

	function automatic utf8_t utf8_enc(input logic [20:0] cp);
		utf8_t r;
		r = '0;
		if (cp < 21'h80) begin
			r.n    = 3'd1;
			r.b[0] = cp[7:0];
		end else if (cp < 21'h800) begin
			r.n    = 3'd2;
			r.b[0] = {3'b110, cp[10:6]};
			r.b[1] = {2'b10, cp[5:0]};
		end else if (cp < 21'h10000) begin
			r.n    = 3'd3;
			r.b[0] = {4'b1110, cp[15:12]};
			r.b[1] = {2'b10, cp[11:6]};
			r.b[2] = {2'b10, cp[5:0]};
		end else begin
			r.n    = 3'd4;
			r.b[0] = {5'b11110, cp[20:18]};
			r.b[1] = {2'b10, cp[17:12]};
			r.b[2] = {2'b10, cp[11:6]};
			r.b[3] = {2'b10, cp[5:0]};
		end
		return r;
	endfunction

endpackage

// ===== sv/jsu_front.sv =====
// ----------------------------------------------------------------------------
// jsu_front
// Input side: classifies each raw byte as hex digit or not and queues it
// for the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_front #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	output logic            full,
	input  logic [7:0]      in_byte,
	input  logic            last,
	input  logic            lnk_pop,
	output logic            lnk_empty,
	output jsu_pkg::lnk_t   lnk_data
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::lnk_t mem_q [DEPTH];
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          wr_en, rd_en;

	assign full      = (cnt_q == CW'(DEPTH));
	assign lnk_empty = (cnt_q == '0);
	assign wr_en     = push && !full;
	assign rd_en     = lnk_pop && !lnk_empty;
	assign lnk_data  = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	// classify on the way in
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= '{ent: jsu_pkg::classify(in_byte), last: last};
		end
	end

endmodule

// ===== sv/jsu_back.sv =====
// ----------------------------------------------------------------------------
// jsu_back
// Decoder: walks the queued and replayed bytes one a cycle through the escape
// state machine and sends UTF-8 bytes one a cycle unless a full result queue stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            lnk_empty,
	input  jsu_pkg::lnk_t   lnk_data,
	output logic            lnk_pop,
	input  logic            res_full,
	output logic            res_push,
	output jsu_pkg::res_t   res_data
);

	jsu_pkg::bk_state_t state_q, state_d;
	jsu_pkg::mode_t     mode_q, mode_d;

	jsu_pkg::ent_t rb_q [jsu_pkg::RbDepth];
	jsu_pkg::ent_t rb_d [jsu_pkg::RbDepth];
	jsu_pkg::ent_t rb_sh [jsu_pkg::RbDepth];
	jsu_pkg::ent_t rb_pre [jsu_pkg::RbDepth];
	jsu_pkg::ent_t hb_q [jsu_pkg::HbDepth];
	jsu_pkg::ent_t hb_d [jsu_pkg::HbDepth];

	logic [2:0]      rcnt_q, rcnt_d;
	logic [2:0]      hc_q, hc_d;
	logic [15:0]     hex_q, hex_d, hex_sh;
	logic [9:0]      hsur_q, hsur_d;
	logic            bad_q, bad_d, bad_n;
	logic            last_q, last_d;
	logic [3:0]      cnt_q, cnt_d;
	logic [7:0]      pend_q, pend_d;
	logic            pend_v_q, pend_v_d;
	logic [2:0][7:0] em_q, em_d;
	logic [1:0]      em_n_q, em_n_d;

	jsu_pkg::ent_t   cur;
	jsu_pkg::utf8_t  enc;
	logic            e_req, e_raw, load, push_req, adv, ok;
	logic [7:0]      e_byte_raw, e_first;
	logic [20:0]     e_cp;

	// next byte to decode leaves the front of the replay line
	always_comb begin
		for (int i = 0; i < jsu_pkg::RbDepth - 1; i++) begin
			rb_sh[i] = rb_q[i + 1];
		end
		rb_sh[jsu_pkg::RbDepth - 1] = rb_q[jsu_pkg::RbDepth - 1];
	end

	// held bytes go back in front of whatever is still waiting
	always_comb begin
		for (int i = 0; i < jsu_pkg::HbDepth; i++) begin
			rb_pre[i] = (3'(i) < hc_q) ? hb_q[i] : rb_q[3'(i) - hc_q];
		end
		rb_pre[jsu_pkg::RbDepth - 1] = rb_q[3'(jsu_pkg::RbDepth - 1) - hc_q];
	end

	assign cur    = rb_q[0];
	assign hex_sh = {hex_q[11:0], cur.hv};
	assign bad_n  = bad_q | ~cur.hok;

	always_comb begin
		state_d    = state_q;
		mode_d     = mode_q;
		rb_d       = rb_q;
		rcnt_d     = rcnt_q;
		hb_d       = hb_q;
		hc_d       = hc_q;
		hex_d      = hex_q;
		hsur_d     = hsur_q;
		bad_d      = bad_q;
		last_d     = last_q;
		cnt_d      = cnt_q;
		pend_d     = pend_q;
		pend_v_d   = pend_v_q;
		em_d       = em_q;
		em_n_d     = em_n_q;
		push_req   = 1'b0;
		res_data   = '0;
		e_req      = 1'b0;
		e_raw      = 1'b1;
		e_byte_raw = '0;
		e_cp       = '0;
		load       = 1'b0;
		ok         = 1'b0;

		case (state_q)
			jsu_pkg::BK_IDLE: begin
				load = !lnk_empty;
			end

			jsu_pkg::BK_RUN: begin
				if (rcnt_q != '0) begin
					case (mode_q)
						jsu_pkg::MD_PLAIN: begin
							rb_d   = rb_sh;
							rcnt_d = rcnt_q - 1'b1;
							if (cur.b == jsu_pkg::ChBslash) begin
								mode_d = jsu_pkg::MD_ESC;
							end else begin
								e_req      = 1'b1;
								e_byte_raw = cur.b;
							end
						end

						jsu_pkg::MD_ESC: begin
							rb_d   = rb_sh;
							rcnt_d = rcnt_q - 1'b1;
							mode_d = jsu_pkg::MD_PLAIN;
							e_req  = 1'b1;
							case (cur.b)
								jsu_pkg::ChLowB: e_byte_raw = jsu_pkg::CtlBs;
								jsu_pkg::ChLowF: e_byte_raw = jsu_pkg::CtlFf;
								jsu_pkg::ChLowN: e_byte_raw = jsu_pkg::CtlLf;
								jsu_pkg::ChLowR: e_byte_raw = jsu_pkg::CtlCr;
								jsu_pkg::ChLowT: e_byte_raw = jsu_pkg::CtlHt;
								jsu_pkg::ChLowU: begin
									e_req  = 1'b0;
									mode_d = jsu_pkg::MD_HEX;
									hc_d   = '0;
									bad_d  = 1'b0;
								end
								default: e_byte_raw = cur.b;
							endcase
						end

						jsu_pkg::MD_HEX: begin
							if (hc_q == 3'd3) begin
								mode_d = jsu_pkg::MD_PLAIN;
								hc_d   = '0;
								if (bad_n) begin
									// not four hex digits: 'u' then decode them again
									e_req      = 1'b1;
									e_byte_raw = jsu_pkg::ChLowU;
									rb_d       = rb_pre;
									rcnt_d     = rcnt_q + hc_q;
								end else begin
									rb_d   = rb_sh;
									rcnt_d = rcnt_q - 1'b1;
									hex_d  = hex_sh;
									if (hex_sh[15:10] == jsu_pkg::SurHiTag) begin
										hsur_d = hex_sh[9:0];
										mode_d = jsu_pkg::MD_PAIR;
									end else begin
										e_req = 1'b1;
										e_raw = 1'b0;
										e_cp  = (hex_sh[15:10] == jsu_pkg::SurLoTag) ?
											jsu_pkg::CpRepl : {5'd0, hex_sh};
									end
								end
							end else begin
								rb_d       = rb_sh;
								rcnt_d     = rcnt_q - 1'b1;
								hb_d[hc_q] = cur;
								hc_d       = hc_q + 1'b1;
								hex_d      = hex_sh;
								bad_d      = bad_n;
							end
						end

						jsu_pkg::MD_PAIR: begin
							case (hc_q)
								3'd0:    ok = (cur.b == jsu_pkg::ChBslash);
								3'd1:    ok = (cur.b == jsu_pkg::ChLowU);
								default: ok = cur.hok;
							endcase
							if (ok && hc_q == 3'd5
								&& hex_sh[15:10] == jsu_pkg::SurLoTag) begin
								// complete pair
								rb_d   = rb_sh;
								rcnt_d = rcnt_q - 1'b1;
								hex_d  = hex_sh;
								hc_d   = '0;
								mode_d = jsu_pkg::MD_PLAIN;
								e_req  = 1'b1;
								e_raw  = 1'b0;
								e_cp   = jsu_pkg::SuppBase + {1'b0, hsur_q, hex_sh[9:0]};
							end else if (!ok || hc_q == 3'd5) begin
								// lone high surrogate, decode the held tail again
								mode_d = jsu_pkg::MD_PLAIN;
								hc_d   = '0;
								rb_d   = rb_pre;
								rcnt_d = rcnt_q + hc_q;
								e_req  = 1'b1;
								e_raw  = 1'b0;
								e_cp   = jsu_pkg::CpRepl;
							end else begin
								rb_d       = rb_sh;
								rcnt_d     = rcnt_q - 1'b1;
								hb_d[hc_q] = cur;
								hc_d       = hc_q + 1'b1;
								hex_d      = hex_sh;
							end
						end

						default: mode_d = jsu_pkg::MD_PLAIN;
					endcase
				end else if (last_q && mode_q != jsu_pkg::MD_PLAIN) begin
					// string ends inside an escape
					mode_d = jsu_pkg::MD_PLAIN;
					hc_d   = '0;
					if (mode_q == jsu_pkg::MD_HEX || mode_q == jsu_pkg::MD_PAIR) begin
						rb_d   = rb_pre;
						rcnt_d = rcnt_q + hc_q;
					end
					if (mode_q == jsu_pkg::MD_PAIR) begin
						e_req = 1'b1;
						e_raw = 1'b0;
						e_cp  = jsu_pkg::CpRepl;
					end
				end else begin
					// item done: release the held-back byte, marked if last
					if (last_q) begin
						push_req = 1'b1;
						res_data = pend_v_q ? jsu_pkg::res_t'{pend_q, 1'b1, 1'b1}
							: jsu_pkg::res_t'{8'h00, 1'b0, 1'b1};
						hc_d     = '0;
					end else if (pend_v_q) begin
						push_req = 1'b1;
						res_data = '{pend_q, 1'b1, 1'b0};
					end
					pend_v_d = 1'b0;
					if (!lnk_empty) begin
						load = 1'b1;
					end else begin
						state_d = jsu_pkg::BK_IDLE;
					end
				end
			end

			jsu_pkg::BK_EMIT: begin
				e_req      = 1'b1;
				e_byte_raw = em_q[0];
				em_d       = {8'h00, em_q[2], em_q[1]};
				em_n_d     = em_n_q - 1'b1;
				if (em_n_q == 2'd1) begin
					state_d = jsu_pkg::BK_RUN;
				end
			end

			default: state_d = jsu_pkg::BK_IDLE;
		endcase

		// utf-8 continuation bytes go out over the following cycles
		enc     = jsu_pkg::utf8_enc(e_cp);
		e_first = e_raw ? e_byte_raw : enc.b[0];
		if (e_req && !e_raw && enc.n > 3'd1) begin
			state_d = jsu_pkg::BK_EMIT;
			em_d    = {enc.b[3], enc.b[2], enc.b[1]};
			em_n_d  = 2'(enc.n - 3'd1);
		end

		// one byte is held back so the end mark can land on it
		if (e_req && cnt_q < jsu_pkg::MaxRes) begin
			if (pend_v_q) begin
				push_req = 1'b1;
				res_data = '{pend_q, 1'b1, 1'b0};
			end
			pend_d   = e_first;
			pend_v_d = 1'b1;
			cnt_d    = cnt_q + 4'd1;
		end

		if (load) begin
			rb_d[0] = lnk_data.ent;
			rcnt_d  = 3'd1;
			last_d  = lnk_data.last;
			cnt_d   = '0;
			state_d = jsu_pkg::BK_RUN;
		end
	end

	assign adv      = !(push_req && res_full);
	assign res_push = push_req && adv;
	assign lnk_pop  = load && adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= jsu_pkg::BK_IDLE;
			mode_q   <= jsu_pkg::MD_PLAIN;
			rcnt_q   <= '0;
			hc_q     <= '0;
			last_q   <= 1'b0;
			cnt_q    <= '0;
			pend_v_q <= 1'b0;
			em_n_q   <= '0;
		end else if (adv) begin
			state_q  <= state_d;
			mode_q   <= mode_d;
			rcnt_q   <= rcnt_d;
			hc_q     <= hc_d;
			last_q   <= last_d;
			cnt_q    <= cnt_d;
			pend_v_q <= pend_v_d;
			em_n_q   <= em_n_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rb_q   <= rb_d;
			hb_q   <= hb_d;
			hex_q  <= hex_d;
			hsur_q <= hsur_d;
			bad_q  <= bad_d;
			pend_q <= pend_d;
			em_q   <= em_d;
		end
	end

endmodule

// ===== sv/jsu_resq.sv =====
// ----------------------------------------------------------------------------
// jsu_resq
// Result queue: holds finished result requests until the consumer pops
// them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_resq #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            res_push,
	output logic            res_full,
	input  jsu_pkg::res_t   res_data,
	input  logic            pop,
	output logic            empty,
	output logic [7:0]      out_byte,
	output logic            byte_valid,
	output logic            end_of_string
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jsu_pkg::res_t mem_q [DEPTH];
	jsu_pkg::res_t head;
	logic [PW-1:0] wr_q, rd_q;
	logic [CW-1:0] cnt_q;
	logic          wr_en, rd_en;

	assign res_full      = (cnt_q == CW'(DEPTH));
	assign empty         = (cnt_q == '0);
	assign wr_en         = res_push && !res_full;
	assign rd_en         = pop && !empty;
	assign head          = mem_q[rd_q];
	assign out_byte      = head.out_byte;
	assign byte_valid    = head.byte_valid;
	assign end_of_string = head.eos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (rd_en) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_q] <= res_data;
		end
	end

endmodule

// ===== sv/json_string_unescape_utf8.sv =====
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Streams the raw bytes between a JSON string's quotes, one byte per push,
// and gives back the unescaped text as UTF-8 bytes through a result queue.
// Simple escapes become their control characters, an unknown escape letter
// comes out as itself, \uXXXX becomes one to three UTF-8 bytes and a high and
// low surrogate pair is joined into one supplementary character. A lone
// surrogate becomes U+FFFD; a \u with bad hex gives 'u' and the bytes after
// it are decoded again; a \u cut short by the string end is dropped and its
// digits decoded again, and a trailing backslash is dropped. Mark the final
// byte of a string with last: its final result carries end_of_string, and
// if it yields no byte a bare end marker (byte_valid low, out_byte zero) is
// returned instead. Timing: the back end decodes one byte per cycle unless
// stalled; a plain byte is decoded, then its result is handed over as the
// next byte is taken up. Extra bytes of a multi-byte UTF-8 character go out
// one at a time, held bytes decoded again pass the decoder once more, and a
// string ending inside an escape is settled before its end mark. A full
// result queue stalls the decoder until a pop frees a slot. A short queue on
// each side keeps pushes and pops apart from the decoder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module json_string_unescape_utf8 #(
	parameter int LINK_DEPTH = 2,
	parameter int RES_DEPTH  = 2
) (
	input  logic       clk,
	input  logic       arst_n,
	// input side
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_byte,
	input  logic       last,
	// result side
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       byte_valid,
	output logic       end_of_string
);

	// link between front and back end
	logic          lnk_pop;
	logic          lnk_empty;
	jsu_pkg::lnk_t lnk_data;

	// result requests from the decoder
	logic          res_push;
	logic          res_full;
	jsu_pkg::res_t res_data;

	// front: hex digit classification and input queue
	jsu_front #(
		.DEPTH (LINK_DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.in_byte   (in_byte),
		.last      (last),
		.lnk_pop   (lnk_pop),
		.lnk_empty (lnk_empty),
		.lnk_data  (lnk_data)
	);

	// back: escape decoding, replay of held bytes and utf-8 output
	jsu_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.lnk_empty (lnk_empty),
		.lnk_data  (lnk_data),
		.lnk_pop   (lnk_pop),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	// result queue towards the consumer
	jsu_resq #(
		.DEPTH (RES_DEPTH)
	) u_resq (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_push      (res_push),
		.res_full      (res_full),
		.res_data      (res_data),
		.pop           (pop),
		.empty         (empty),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.end_of_string (end_of_string)
	);

endmodule

// ===== sv/jsu_chk.sv =====
// ----------------------------------------------------------------------------
// jsu_chk
// Port-level checks of the JSON string unescaper, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module jsu_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       push,
	input logic       full,
	input logic       last,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       byte_valid,
	input logic       end_of_string
);

	// strings accepted whose end mark has not been popped yet
	logic [7:0] open_q;
	logic       last_in, eos_out;

	assign last_in = push && !full && last;
	assign eos_out = pop && !empty && end_of_string;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
		end else if (last_in && !eos_out) begin
			open_q <= open_q + 8'd1;
		end else if (eos_out && !last_in) begin
			open_q <= open_q - 8'd1;
		end
	end

	// a bare marker only ever closes a string
	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !byte_valid |-> end_of_string && out_byte == 8'h00)
		else $error("bare result that is not an end marker");

	// an end mark needs a string whose last byte came in earlier
	a_eos_owed: assert property (@(posedge clk) disable iff (!arst_n)
		eos_out |-> open_q != 8'd0)
		else $error("end of string without a pending last byte");

	// head result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_byte) && $stable(byte_valid)
			&& $stable(end_of_string))
		else $error("waiting result changed before pop");

	// nothing to deliver straight after reset
	a_reset: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> empty)
		else $error("result present right after reset");

endmodule

bind json_string_unescape_utf8 jsu_chk u_chk (.*);
